>>> sv/rlt_pkg.sv
// Shared constants and types for the region lock table.
`default_nettype none

package rlt_pkg;

    // Table dimensions
    localparam int unsigned MAX_PROCESSES     = 64;
    localparam int unsigned SLOTS_PER_PROCESS = 128;
    localparam int unsigned ADDRESS_BITS      = 64;

    // Fixed field widths
    localparam int unsigned ID_W      = 32;
    localparam int unsigned IN_ADDR_W = 64;
    localparam int unsigned SIZE_W    = 32;

    // Derived widths
    localparam int unsigned PROC_IW     = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int unsigned PROC_CW     = $clog2(MAX_PROCESSES + 1);
    localparam int unsigned SLOT_IW     = (SLOTS_PER_PROCESS > 1) ?
                                          $clog2(SLOTS_PER_PROCESS) : 1;
    localparam int unsigned SLOT_CW     = $clog2(SLOTS_PER_PROCESS + 1);
    localparam int unsigned TOTAL_SLOTS = MAX_PROCESSES * SLOTS_PER_PROCESS;
    localparam int unsigned SLOT_AW     = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int unsigned SLOT_DW     = ADDRESS_BITS + SIZE_W;

    // Request kinds
    localparam logic KIND_LOCK   = 1'b0;
    localparam logic KIND_UNLOCK = 1'b1;

    // Result codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_ROW,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

>>> sv/rlt_ram.sv
// Simple dual-port synchronous RAM with one write and one registered read port.
`default_nettype none

module rlt_ram #(
    parameter  int unsigned WIDTH = 8,
    parameter  int unsigned DEPTH = 16,
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/region_lock_table_top.sv
// Top level of the per-process region lock table.
// Usage:
//   Request channel: i_in_valid / o_in_stall with i_kind, i_process_id,
//   i_region_address and i_region_size. A transfer happens at a clock edge
//   with i_in_valid high and o_in_stall low. One request is worked at a time;
//   o_in_stall is low only while the engine is idle.
//   Result channel: o_out_valid / i_out_stall with o_status (0 success,
//   1 failure). Exactly one result per request, in request order.
//   A request runs an id search that compares registered process ids in
//   turn (all registered ids on a miss), then on an id hit a read of the
//   process's held-bit row, then a slot search: a lock stops at the first
//   free slot, an unlock at the held slot whose address and size match, and
//   a failed lock or unlock searches every slot. A full-table failure ends
//   after the id search. The id search and the slot search read one memory
//   entry per cycle. The engine returns to idle as the result loads. A
//   result waits in an output register; under receiver stall the engine
//   holds in its final state until the register frees.
//   Reset (synchronous, active low) empties the process table and drops any
//   pending result; a process's held-bit row is written whole on registration.
`default_nettype none

module region_lock_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [31:0] i_process_id,
    input  logic [63:0] i_region_address,
    input  logic [31:0] i_region_size,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status
);

    localparam int unsigned SLOTS = rlt_pkg::SLOTS_PER_PROCESS;

    // State machine
    rlt_pkg::t_state r_state;
    rlt_pkg::t_state n_state;

    // Latched request
    logic                             r_kind;
    logic [rlt_pkg::ID_W-1:0]         r_id;
    logic [rlt_pkg::ADDRESS_BITS-1:0] r_addr;
    logic [rlt_pkg::SIZE_W-1:0]       r_size;

    // Process table bookkeeping
    logic [rlt_pkg::PROC_CW-1:0] r_proc_count;
    logic [rlt_pkg::PROC_CW-1:0] r_iss;
    logic [rlt_pkg::PROC_IW-1:0] r_cmp_idx;
    logic [rlt_pkg::PROC_IW-1:0] r_pidx;
    logic                        r_have_proc;
    logic [rlt_pkg::SLOT_AW-1:0] r_base;

    // Slot search
    logic                        r_pend;
    logic [SLOTS-1:0]            r_row;
    logic [rlt_pkg::SLOT_CW-1:0] r_j;
    logic [rlt_pkg::SLOT_IW-1:0] r_sidx;
    logic                        r_status_res;

    // Output register
    logic r_out_valid;
    logic r_status;

    // Memory ports
    logic                        id_we;
    logic [rlt_pkg::PROC_IW-1:0] id_waddr;
    logic [rlt_pkg::PROC_IW-1:0] id_raddr;
    logic [rlt_pkg::ID_W-1:0]    id_rdata;

    logic                        row_we;
    logic [rlt_pkg::PROC_IW-1:0] row_waddr;
    logic [rlt_pkg::PROC_IW-1:0] row_raddr;
    logic [SLOTS-1:0]            row_rdata;

    logic                        slot_we;
    logic [rlt_pkg::SLOT_AW-1:0] slot_waddr;
    logic [rlt_pkg::SLOT_AW-1:0] slot_raddr;
    logic [rlt_pkg::SLOT_DW-1:0] slot_wdata;
    logic [rlt_pkg::SLOT_DW-1:0] slot_rdata;

    // Decision terms
    logic                        accept;
    logic                        lk_hit;
    logic                        lk_miss;
    logic                        tbl_full;
    logic [rlt_pkg::SLOT_IW-1:0] j_idx;
    logic                        lock_free;
    logic                        lock_last;
    logic                        un_hit;
    logic                        un_done;
    logic                        out_free;
    logic [rlt_pkg::SLOT_AW-1:0] slot_addr_j;

    assign accept    = (r_state == rlt_pkg::ST_IDLE) && i_in_valid;
    assign lk_hit    = r_pend && (id_rdata == r_id);
    assign lk_miss   = !lk_hit && (r_iss == r_proc_count);
    assign tbl_full  = (r_proc_count == rlt_pkg::PROC_CW'(rlt_pkg::MAX_PROCESSES));
    assign j_idx     = r_j[rlt_pkg::SLOT_IW-1:0];
    assign lock_free = !r_row[j_idx];
    assign lock_last = (r_j == rlt_pkg::SLOT_CW'(SLOTS - 1));
    assign un_hit    = r_pend && r_row[r_sidx] && (slot_rdata == {r_addr, r_size});
    assign un_done   = (r_j == rlt_pkg::SLOT_CW'(SLOTS));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign slot_addr_j = r_base + rlt_pkg::SLOT_AW'(j_idx);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rlt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = rlt_pkg::ST_LOOKUP;
                end
            end
            rlt_pkg::ST_LOOKUP: begin
                if (lk_hit) begin
                    n_state = rlt_pkg::ST_ROW;
                end else if (lk_miss) begin
                    n_state = tbl_full ? rlt_pkg::ST_FINISH : rlt_pkg::ST_SCAN;
                end
            end
            rlt_pkg::ST_ROW: begin
                n_state = rlt_pkg::ST_SCAN;
            end
            rlt_pkg::ST_SCAN: begin
                if (r_kind == rlt_pkg::KIND_LOCK) begin
                    if (lock_free || lock_last) begin
                        n_state = rlt_pkg::ST_FINISH;
                    end
                end else if (un_hit || un_done) begin
                    n_state = rlt_pkg::ST_FINISH;
                end
            end
            rlt_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = rlt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rlt_pkg::ST_IDLE;
            end
        endcase
    end

    // State machine outputs: handshake and memory controls
    always_comb begin
        o_in_stall = (r_state != rlt_pkg::ST_IDLE);
        id_raddr   = r_iss[rlt_pkg::PROC_IW-1:0];
        id_we      = (r_state == rlt_pkg::ST_LOOKUP) && lk_miss && !tbl_full;
        id_waddr   = r_proc_count[rlt_pkg::PROC_IW-1:0];
        row_raddr  = r_cmp_idx;
        row_we     = (r_state == rlt_pkg::ST_FINISH) && out_free && r_have_proc;
        row_waddr  = r_pidx;
        slot_raddr = un_done ? r_base : slot_addr_j;
        slot_we    = (r_state == rlt_pkg::ST_SCAN) && (r_kind == rlt_pkg::KIND_LOCK) &&
                     lock_free;
        slot_waddr = slot_addr_j;
        slot_wdata = {r_addr, r_size};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Process count: advance on each registration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc_count <= '0;
        end else if (id_we) begin
            r_proc_count <= r_proc_count + rlt_pkg::PROC_CW'(1);
        end
    end

    // Request latch, id search and slot search
    always_ff @(posedge i_clk) begin
        case (r_state)
            rlt_pkg::ST_IDLE: begin
                if (accept) begin
                    r_kind       <= i_kind;
                    r_id         <= i_process_id;
                    r_addr       <= i_region_address[rlt_pkg::ADDRESS_BITS-1:0];
                    r_size       <= i_region_size;
                    r_iss        <= '0;
                    r_pend       <= 1'b0;
                    r_have_proc  <= 1'b0;
                    r_status_res <= rlt_pkg::STATUS_FAIL;
                end
            end
            rlt_pkg::ST_LOOKUP: begin
                if (lk_hit) begin
                    r_pidx      <= r_cmp_idx;
                    r_have_proc <= 1'b1;
                    r_base      <= rlt_pkg::SLOT_AW'(r_cmp_idx) *
                                   rlt_pkg::SLOT_AW'(SLOTS);
                    r_j         <= '0;
                    r_pend      <= 1'b0;
                end else if (lk_miss) begin
                    // Register the new id with every slot free, unless the table is full
                    r_pidx      <= r_proc_count[rlt_pkg::PROC_IW-1:0];
                    r_have_proc <= !tbl_full;
                    r_base      <= rlt_pkg::SLOT_AW'(r_proc_count[rlt_pkg::PROC_IW-1:0]) *
                                   rlt_pkg::SLOT_AW'(SLOTS);
                    r_row       <= '0;
                    r_j         <= '0;
                    r_pend      <= 1'b0;
                end else begin
                    r_cmp_idx <= r_iss[rlt_pkg::PROC_IW-1:0];
                    r_pend    <= 1'b1;
                    r_iss     <= r_iss + rlt_pkg::PROC_CW'(1);
                end
            end
            rlt_pkg::ST_ROW: begin
                r_row <= row_rdata;
            end
            rlt_pkg::ST_SCAN: begin
                if (r_kind == rlt_pkg::KIND_LOCK) begin
                    if (lock_free) begin
                        r_row[j_idx] <= 1'b1;
                        r_status_res <= rlt_pkg::STATUS_OK;
                    end else begin
                        r_j <= r_j + rlt_pkg::SLOT_CW'(1);
                    end
                end else begin
                    if (un_hit) begin
                        r_row[r_sidx] <= 1'b0;
                        r_status_res  <= rlt_pkg::STATUS_OK;
                    end else if (!un_done) begin
                        r_sidx <= j_idx;
                        r_pend <= 1'b1;
                        r_j    <= r_j + rlt_pkg::SLOT_CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: load on finish, drop when the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == rlt_pkg::ST_FINISH) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == rlt_pkg::ST_FINISH) && out_free) begin
            r_status <= r_status_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

    // Registered process ids
    rlt_ram #(
        .WIDTH (rlt_pkg::ID_W),
        .DEPTH (rlt_pkg::MAX_PROCESSES)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (id_waddr),
        .i_wdata (r_id),
        .i_raddr (id_raddr),
        .o_rdata (id_rdata)
    );

    // One row of held bits per process
    rlt_ram #(
        .WIDTH (SLOTS),
        .DEPTH (rlt_pkg::MAX_PROCESSES)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (r_row),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    // Address and size of every slot
    rlt_ram #(
        .WIDTH (rlt_pkg::SLOT_DW),
        .DEPTH (rlt_pkg::TOTAL_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_proc_count <= rlt_pkg::PROC_CW'(rlt_pkg::MAX_PROCESSES))
        else $error("process count beyond table size");

    a_count_only_on_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != rlt_pkg::ST_LOOKUP) |=> $stable(r_proc_count))
        else $error("process count changed outside id search");

    a_slot_write_on_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slot_we |-> (r_state == rlt_pkg::ST_SCAN) && (r_kind == rlt_pkg::KIND_LOCK) &&
                    r_have_proc)
        else $error("slot written outside a lock");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == rlt_pkg::ST_FINISH))
        else $error("result loaded outside finish");

endmodule

`default_nettype wire
